[hdl/packed_pixel_bitmap_store_assert.svh]
// Assertion macros for the packed pixel bitmap store.
// Included by the top level; no other dependencies.
`ifndef PACKED_PIXEL_BITMAP_STORE_ASSERT_SVH
`define PACKED_PIXEL_BITMAP_STORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PPBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PPBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PPBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/ppbs_pkg.sv]
// Shared types, codes and pixel helpers for the packed pixel bitmap store.
// No dependencies.
package ppbs_pkg;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_LOCKED  = 2'd2;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DEPTH  = 3'd2;
    localparam logic [2:0] CFG_LOCK   = 3'd3;

    localparam logic [2:0] DEPTH_RESET = 3'd3;

    typedef struct packed {
        logic capture;
        logic calc;
        logic fill_step;
        logic pix_commit;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic pix_go;
        logic fill_go;
        logic fill_end;
    } t_dp_stat;

    // log2 of bits per pixel; unused codes act as 32 bits
    function automatic logic [2:0] depth_log2(input logic [2:0] code);
        return (code > 3'd5) ? 3'd5 : code;
    endfunction

    function automatic logic [31:0] pix_mask(input logic [2:0] lg);
        logic [31:0] m;
        case (lg)
            3'd0:    m = 32'h0000_0001;
            3'd1:    m = 32'h0000_0003;
            3'd2:    m = 32'h0000_000F;
            3'd3:    m = 32'h0000_00FF;
            3'd4:    m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] fill_word(input logic [31:0] v, input logic [2:0] lg);
        logic [31:0] w;
        case (lg)
            3'd0:    w = {32{v[0]}};
            3'd1:    w = {16{v[1:0]}};
            3'd2:    w = {8{v[3:0]}};
            3'd3:    w = {4{v[7:0]}};
            3'd4:    w = {2{v[15:0]}};
            default: w = v;
        endcase
        return w;
    endfunction

endpackage

[hdl/packed_pixel_bitmap_store.sv]
// Pixel read or write steps through CALC, READ and MODIFY before the registered result strobe;
// refused, out-of-bounds and no-op items go CALC then DONE; fill goes CALC, FILL (one word each step), DONE.
// A new item is accepted only in IDLE, once the previous one has finished; the single memory
// port does read then write-back for pixel items; fill is bound by one word write per cycle.
// Synchronous active-low reset clears control and config; memory is not cleared.
// Results are shown one cycle under o_strobe; the receiver cannot stall.
`include "packed_pixel_bitmap_store_assert.svh"
module packed_pixel_bitmap_store #(
    parameter int MEM_WORDS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [31:0]        i_pixel_value,
    output logic               o_strobe,
    output logic [31:0]        o_read_data,
    output logic [1:0]         o_status
);
    import ppbs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    ppbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    ppbs_dp #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_value (i_pixel_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_read_data   (o_read_data),
        .o_status      (o_status)
    );

    `PPBS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `PPBS_ASSERT_IMPLIES(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))
    `PPBS_ASSERT_IMPLIES(a_refused_no_data, i_clk, i_rst_n, o_strobe && (o_status != ST_OK), o_read_data == 32'd0)
    `PPBS_ASSERT_IMPLIES(a_strobe_single, i_clk, i_rst_n, o_strobe, !$past(o_strobe))

endmodule

[hdl/ppbs_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module ppbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ppbs_ctrl.sv]
// Sequencing state machine for the packed pixel bitmap store.
// Depends on ppbs_pkg.
module ppbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ppbs_pkg::t_dp_stat i_stat,
    output ppbs_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_strobe
);
    import ppbs_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CALC   = 6'b000010,
        S_READ   = 6'b000100,
        S_MODIFY = 6'b001000,
        S_FILL   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    logic    r_strobe;
    t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.capture = 1'b1;
                    n_state     = S_CALC;
                end
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                if (i_stat.pix_go) begin
                    n_state = S_READ;
                end else if (i_stat.fill_go) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_state = S_MODIFY;
            end
            S_MODIFY: begin
                cmd.pix_commit = 1'b1;
                cmd.finish     = 1'b1;
                n_state        = S_IDLE;
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                if (i_stat.fill_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= cmd.finish;
        end
    end

    assign o_cmd    = cmd;
    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

[hdl/ppbs_dp.sv]
// Datapath: configuration registers, address arithmetic, pixel merge and word memory.
// Depends on ppbs_pkg and ppbs_ram.
module ppbs_dp #(
    parameter int MEM_WORDS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [31:0]        i_pixel_value,
    input  ppbs_pkg::t_dp_cmd  i_cmd,
    output ppbs_pkg::t_dp_stat o_stat,
    output logic [31:0]        o_read_data,
    output logic [1:0]         o_status
);
    import ppbs_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int CW = $clog2(MEM_WORDS + 1);
    localparam logic [31:0] MEM_W32 = 32'(MEM_WORDS);

    logic [14:0] r_width, r_height;
    logic [2:0]  r_depth;
    logic        r_locked;

    logic [1:0]  r_mode;
    logic [15:0] r_px, r_py;
    logic [31:0] r_val;
    logic [31:0] r_addr;
    logic [4:0]  r_shift;
    logic [CW-1:0] r_cnt;
    logic [31:0] r_read_data;
    logic [1:0]  r_status;

    logic [2:0]  lg;
    logic [31:0] mask;
    logic [20:0] row_bits;
    logic [15:0] stride;
    logic [19:0] pos;
    logic [14:0] mul_a;
    logic [31:0] addr_calc;
    logic [4:0]  shift_calc;
    logic        in_bounds, is_pix, locked_ref, addr_ok;
    logic [1:0]  status;
    logic [31:0] cnt32;
    logic        fill_end;
    logic [31:0] rdata, pixel, merged;
    logic        we;
    logic [AW-1:0] ram_addr;
    logic [31:0] wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_depth  <= DEPTH_RESET;
            r_locked <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_DEPTH:  r_depth  <= i_cfg_data[2:0];
                CFG_LOCK:   r_locked <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign lg       = depth_log2(r_depth);
    assign mask     = pix_mask(lg);
    assign row_bits = (21'(r_width) << lg) + 21'd31;
    assign stride   = row_bits[20:5];
    assign pos      = 20'(r_px[14:0]) << lg;

    assign mul_a      = (r_mode == MODE_FILL) ? r_height : r_py[14:0];
    assign addr_calc  = (32'(mul_a) * 32'(stride))
                      + ((r_mode == MODE_FILL) ? 32'd0 : 32'(pos[19:5]));
    assign shift_calc = {pos[4:3], 3'b000}
                      + ((lg < 3'd3) ? (5'd8 - (5'd1 << lg) - {2'b00, pos[2:0]}) : 5'd0);

    assign is_pix     = (r_mode == MODE_READ) || (r_mode == MODE_WRITE);
    assign in_bounds  = !r_px[15] && (r_px[14:0] < r_width)
                     && !r_py[15] && (r_py[14:0] < r_height);
    assign locked_ref = r_locked && ((r_mode == MODE_WRITE) || (r_mode == MODE_FILL));
    assign status     = locked_ref ? ST_LOCKED
                      : (is_pix && !in_bounds) ? ST_OUTSIDE : ST_OK;
    assign addr_ok    = (r_addr < MEM_W32);

    assign cnt32    = 32'(r_cnt);
    assign fill_end = (cnt32 >= r_addr) || (cnt32 >= MEM_W32);

    assign o_stat.pix_go   = is_pix && !locked_ref && in_bounds;
    assign o_stat.fill_go  = (r_mode == MODE_FILL) && !r_locked;
    assign o_stat.fill_end = fill_end;

    assign pixel  = (rdata >> r_shift) & mask;
    assign merged = (rdata & ~(mask << r_shift)) | ((r_val & mask) << r_shift);

    always_comb begin
        we       = 1'b0;
        ram_addr = r_addr[AW-1:0];
        wdata    = merged;
        if (i_cmd.fill_step) begin
            ram_addr = r_cnt[AW-1:0];
            wdata    = fill_word(r_val & mask, lg);
            we       = !fill_end;
        end else if (i_cmd.pix_commit) begin
            we = (r_mode == MODE_WRITE) && addr_ok;
        end
    end

    ppbs_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (ram_addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_val  <= i_pixel_value;
        end
        if (i_cmd.calc) begin
            r_addr  <= addr_calc;
            r_shift <= shift_calc;
        end
        if (i_cmd.finish) begin
            r_status    <= status;
            r_read_data <= (i_cmd.pix_commit && (r_mode == MODE_READ) && addr_ok)
                         ? pixel : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.capture) begin
            r_cnt <= '0;
        end else if (i_cmd.fill_step && !fill_end) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_read_data = r_read_data;
    assign o_status    = r_status;

endmodule

[sim/packed_pixel_bitmap_store_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the packed pixel bitmap store: tracks config beats, predicts
// each pixel reply from its own bitmap copy and compares every result beat.
// Depends on ppbs_pkg for the mode, status and register codes.
module packed_pixel_bitmap_store_checker #(
    parameter int MEM_WORDS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic [1:0]         i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [31:0]        i_pixel_value,
    input  logic               i_strobe,
    input  logic [31:0]        i_read_data,
    input  logic [1:0]         i_status,
    output int                 o_fail_count,
    output int                 o_pending
);
    import ppbs_pkg::*;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } t_pixel_reply;

    logic [31:0]  bitmap_words [MEM_WORDS];
    logic [14:0]  row_pixels;
    logic [14:0]  row_count;
    logic [2:0]   depth_sel;
    logic         lock_bit;
    t_pixel_reply pixel_replies[$];
    int           fail_count = 0;

    function automatic t_pixel_reply apply_pixel_command(input logic [1:0] mode,
            input logic signed [15:0] x, input logic signed [15:0] y,
            input logic [31:0] val);
        t_pixel_reply    reply;
        int unsigned     bpp;
        int unsigned     shift;
        logic [31:0]     mask;
        logic [31:0]     word;
        longint unsigned stride;
        longint unsigned bit_pos;
        longint unsigned addr;
        longint unsigned total;
        reply = '0;
        bpp = 32'd1 << ((depth_sel > 3'd5) ? 3'd5 : depth_sel);
        mask = (bpp == 32) ? 32'hFFFF_FFFF : ((32'd1 << bpp) - 32'd1);
        stride = (64'(row_pixels) * bpp + 64'd31) >> 5;
        case (mode)
            MODE_READ, MODE_WRITE: begin
                if (mode == MODE_WRITE && lock_bit) begin
                    reply.status = ST_LOCKED;
                end else if (x[15] || y[15] || x[14:0] >= row_pixels
                             || y[14:0] >= row_count) begin
                    reply.status = ST_OUTSIDE;
                end else begin
                    bit_pos = 64'(x[14:0]) * bpp;
                    addr = 64'(y[14:0]) * stride + (bit_pos >> 5);
                    // byte lane little-endian, sub-byte pixels MSB first
                    shift = 32'(bit_pos & 64'd24);
                    if (bpp < 8) begin
                        shift = shift + 8 - bpp - 32'(bit_pos & 64'd7);
                    end
                    if (addr < MEM_WORDS) begin
                        if (mode == MODE_READ) begin
                            reply.read_data = (bitmap_words[addr] >> shift) & mask;
                        end else begin
                            word = bitmap_words[addr] & ~(mask << shift);
                            bitmap_words[addr] = word | ((val & mask) << shift);
                        end
                    end
                end
            end
            MODE_FILL: begin
                if (lock_bit) begin
                    reply.status = ST_LOCKED;
                end else begin
                    word = '0;
                    for (int unsigned i = 0; i < 32; i += bpp) begin
                        word |= (val & mask) << i;
                    end
                    total = stride * 64'(row_count);
                    if (total > MEM_WORDS) begin
                        total = MEM_WORDS;
                    end
                    for (longint unsigned n = 0; n < total; n++) begin
                        bitmap_words[n] = word;
                    end
                end
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_reply want;
        if (!i_rst_n) begin
            row_pixels = '0;
            row_count  = '0;
            depth_sel  = DEPTH_RESET;
            lock_bit   = 1'b0;
            pixel_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:  row_pixels = i_cfg_data;
                    CFG_HEIGHT: row_count  = i_cfg_data;
                    CFG_DEPTH:  depth_sel  = i_cfg_data[2:0];
                    CFG_LOCK:   lock_bit   = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy) begin
                pixel_replies.push_back(apply_pixel_command(i_mode, i_pos_x, i_pos_y,
                                                            i_pixel_value));
            end
            if (i_strobe) begin
                if (pixel_replies.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat: read_data %h status %0d",
                             $time, i_read_data, i_status);
                end else begin
                    want = pixel_replies.pop_front();
                    if (i_read_data !== want.read_data) begin
                        fail_count++;
                        $display("%0t: read_data mismatch: expected %h, got %h",
                                 $time, want.read_data, i_read_data);
                    end
                    if (i_status !== want.status) begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_status);
                    end
                end
            end
        end
        o_pending    <= pixel_replies.size();
        o_fail_count <= fail_count;
    end

endmodule

[sim/packed_pixel_bitmap_store_tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the packed pixel bitmap store: directed corner
// items, then random bitmap geometries. Depends on ppbs_pkg, the block and
// packed_pixel_bitmap_store_checker.
module packed_pixel_bitmap_store_tb;
    import ppbs_pkg::*;

    localparam int         MEM_WORDS      = 4096;
    localparam int         ITEM_TARGET    = 1600;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] MODE_NONE      = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [14:0]        i_cfg_data;
    logic [1:0]         i_mode;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic [31:0]        i_pixel_value;
    logic               o_strobe;
    logic [31:0]        o_read_data;
    logic [1:0]         o_status;

    int          fail_count;
    int          pending_count;
    int          idle_cycles = 0;
    int          items_sent  = 0;
    int unsigned cur_width;
    int unsigned cur_height;
    bit          quiet_phase = 1'b0;

    packed_pixel_bitmap_store #(
        .MEM_WORDS(MEM_WORDS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_mode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pixel_value(i_pixel_value),
        .o_strobe     (o_strobe),
        .o_read_data  (o_read_data),
        .o_status     (o_status)
    );

    packed_pixel_bitmap_store_checker #(
        .MEM_WORDS(MEM_WORDS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (i_mode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pixel_value(i_pixel_value),
        .i_strobe     (o_strobe),
        .i_read_data  (o_read_data),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet_phase) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] pick_coord(input int unsigned lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6 || lim == 0) begin
            return 16'($urandom);
        end
        if (r < 9) begin
            return 16'hFFFF;
        end
        if (r < 12) begin
            return 16'(lim);
        end
        if (r < 20) begin
            return 16'(lim - 1);
        end
        // keep most hits of a huge bitmap inside the word store
        if (lim > 256 && r < 90) begin
            return 16'($urandom_range(0, 255));
        end
        return 16'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end
        if (r < 20) begin
            return '1;
        end
        return $urandom();
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic [31:0] val);
        int n;
        start         <= 1'b1;
        i_mode        <= mode;
        i_pos_x       <= x;
        i_pos_y       <= y;
        i_pixel_value <= val;
        do @(posedge i_clk); while (busy);
        items_sent++;
        n = pick_gap();
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [14:0] data);
        int n;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        n = pick_gap();
        if (n > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0 || busy);
    endtask

    // new geometry, then a fill so every in-bounds word holds known data
    task automatic set_phase(input int unsigned width, input int unsigned height,
                             input logic [2:0] depth, input bit locked);
        logic [14:0] junk;
        drain();
        junk = $urandom_range(0, 1) ? 15'($urandom) : '0;
        cur_width  = width;
        cur_height = height;
        cfg_write(CFG_WIDTH, 15'(width));
        cfg_write(CFG_HEIGHT, 15'(height));
        cfg_write(CFG_DEPTH, {junk[14:3], depth});
        cfg_write(CFG_LOCK, {junk[14:1], 1'b0});
        i_cfg_valid <= 1'b0;
        send_item(MODE_FILL, 16'($urandom), 16'($urandom), pick_value());
        if (locked) begin
            drain();
            cfg_write(CFG_LOCK, {junk[14:1], 1'b1});
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic random_item(input int fill_pct);
        int         r;
        logic [1:0] mode;
        r = $urandom_range(0, 99);
        if (r < fill_pct) begin
            mode = MODE_FILL;
        end else if (r < fill_pct + 3) begin
            mode = MODE_NONE;
        end else if (r < 55) begin
            mode = MODE_WRITE;
        end else begin
            mode = MODE_READ;
        end
        send_item(mode, pick_coord(cur_width), pick_coord(cur_height), pick_value());
    endtask

    task automatic run_directed();
        // reset geometry is empty: pixel reads and writes land outside
        send_item(MODE_READ, 0, 0, '0);
        send_item(MODE_WRITE, 0, 0, '1);
        send_item(MODE_FILL, 16'sh7FFF, -16'sh8000, '1);
        send_item(MODE_NONE, -1, -1, '1);
        drain();
        // 1 bpp, 33 pixels per row: rows straddle two words
        cfg_write(CFG_WIDTH, 15'd33);
        cfg_write(CFG_HEIGHT, 15'd2);
        cfg_write(CFG_DEPTH, 15'd0);
        cfg_write(CFG_LOCK, 15'd0);
        for (int k = int'(CFG_LOCK) + 1; k < 8; k++) begin
            cfg_write(3'(k), 15'($urandom));
        end
        i_cfg_valid <= 1'b0;
        cur_width  = 33;
        cur_height = 2;
        send_item(MODE_FILL, 0, 0, 32'hAAAA_5555);
        send_item(MODE_WRITE, 32, 1, 32'h0);
        send_item(MODE_READ, 32, 1, '0);
        send_item(MODE_READ, 31, 1, '0);
        send_item(MODE_WRITE, 0, 0, 32'hFFFF_FFFE);
        send_item(MODE_READ, 0, 0, '0);
        send_item(MODE_READ, 33, 0, '0);
        send_item(MODE_READ, -1, 0, '0);
        send_item(MODE_READ, 0, 2, '0);
        send_item(MODE_WRITE, -16'sh8000, 16'sh7FFF, '1);
        drain();
        // widest bitmap at 32 bpp: fill is clipped at the end of the store
        cfg_write(CFG_WIDTH, 15'h7FFF);
        cfg_write(CFG_HEIGHT, 15'h7FFF);
        cfg_write(CFG_DEPTH, 15'd5);
        i_cfg_valid <= 1'b0;
        cur_width  = 32767;
        cur_height = 32767;
        send_item(MODE_FILL, 0, 0, 32'h1234_5678);
        send_item(MODE_READ, 16'sh7FFF, 0, '0);
        send_item(MODE_READ, 4095, 0, '0);
        send_item(MODE_WRITE, 4095, 0, '1);
        send_item(MODE_READ, 4095, 0, '0);
        send_item(MODE_READ, 0, 16'sh7FFF, '0);
        drain();
        // read-only: writes and fills refused ahead of the bounds check
        cfg_write(CFG_LOCK, 15'd1);
        i_cfg_valid <= 1'b0;
        send_item(MODE_WRITE, 0, 0, '0);
        send_item(MODE_FILL, 0, 0, '0);
        send_item(MODE_READ, 4095, 0, '0);
        send_item(MODE_WRITE, -1, -1, '1);
    endtask

    initial begin
        int              r;
        int unsigned     w;
        int unsigned     h;
        int              n;
        int              fill_pct;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_mode        <= MODE_READ;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_pixel_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                case ($urandom_range(0, 2))
                    0:       w = 0;
                    1:       w = 1;
                    default: w = 32767;
                endcase
                case ($urandom_range(0, 2))
                    0:       h = 0;
                    1:       h = 1;
                    default: h = 32767;
                endcase
            end else begin
                w = $urandom_range(1, 48);
                h = $urandom_range(1, 24);
            end
            quiet_phase = ($urandom_range(0, 4) == 0);
            set_phase(w, h, 3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
            fill_pct = (longint'(w) * h > 4096) ? 1 : 4;
            n = $urandom_range(60, 140);
            repeat (n) random_item(fill_pct);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
